### hdl/spgh_pkg.sv
// Shared types, constants and modular helpers for the sparse polynomial
// gradient/Hessian unit. No dependencies.
`default_nettype none
package spgh_pkg;

   localparam logic [63:0] P_MOD    = 64'hFFFF_FFFF_FFFF_FFC5;  // 2^64 - 59
   localparam int          VAR_W    = 6;
   localparam int          MAX_VARS = 64;
   localparam int          HESS_AW  = 2 * VAR_W;
   localparam logic [3:0]  NUM_JOBS = 4'd11;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TERM  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [1:0] TGT_VALUE = 2'd0;
   localparam logic [1:0] TGT_GRAD  = 2'd1;
   localparam logic [1:0] TGT_HESS  = 2'd2;

   localparam logic [1:0] CSR_DEGREE   = 2'd0;
   localparam logic [1:0] CSR_ORDER    = 2'd1;
   localparam logic [1:0] CSR_NUM_VARS = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_FETCH_CAP,
      S_JOB,
      S_CHAIN,
      S_MUL_WAIT,
      S_ACC_RD,
      S_ACC_WR,
      S_RD_WAIT
   } state_type;

   typedef enum logic [1:0] {
      JOB_VALUE,
      JOB_GRAD,
      JOB_HESS
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   i;
      logic [1:0]   j;
   } job_info_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   function automatic logic [63:0] reduce_once(input logic [63:0] a);
      return (a >= P_MOD) ? a - P_MOD : a;
   endfunction

   // both operands already reduced
   function automatic logic [63:0] mod_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, P_MOD})
         s = s - {1'b0, P_MOD};
      return s[63:0];
   endfunction

   // job 0: value, 1..4: gradient entry i, 5..10: Hessian pair (i,j)
   function automatic job_info_type job_info(input logic [3:0] job);
      job_info_type r;
      r = '{kind: JOB_VALUE, i: 2'd0, j: 2'd0};
      case (job)
         4'd1:    r = '{kind: JOB_GRAD, i: 2'd0, j: 2'd0};
         4'd2:    r = '{kind: JOB_GRAD, i: 2'd1, j: 2'd0};
         4'd3:    r = '{kind: JOB_GRAD, i: 2'd2, j: 2'd0};
         4'd4:    r = '{kind: JOB_GRAD, i: 2'd3, j: 2'd0};
         4'd5:    r = '{kind: JOB_HESS, i: 2'd0, j: 2'd1};
         4'd6:    r = '{kind: JOB_HESS, i: 2'd0, j: 2'd2};
         4'd7:    r = '{kind: JOB_HESS, i: 2'd0, j: 2'd3};
         4'd8:    r = '{kind: JOB_HESS, i: 2'd1, j: 2'd2};
         4'd9:    r = '{kind: JOB_HESS, i: 2'd1, j: 2'd3};
         4'd10:   r = '{kind: JOB_HESS, i: 2'd2, j: 2'd3};
         default: r = '{kind: JOB_VALUE, i: 2'd0, j: 2'd0};
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/spgh_mulmod.sv
// Iterative 64x64 modular multiplier mod 2^64-59 on one 32x32 multiplier.
// Depends on spgh_pkg.
`default_nettype none
module spgh_mulmod (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire spgh_pkg::mul_req_type mul_req,
   output spgh_pkg::mul_rsp_type      mul_rsp
);

   logic         run_ff, run_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         done_ff, done_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in, prod_ff, prod_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [70:0]  t71;
   logic [64:0]  u65;
   logic [63:0]  v64;

   always_comb begin
      a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp     = 64'(a_half) * 64'(b_half);
      // 2^64 = 59 mod p: fold the high half twice
      t71    = {7'b0, acc_ff[63:0]} + {7'b0, acc_ff[127:64]} * 71'd59;
      u65    = {1'b0, acc_ff[63:0]} + 65'(acc_ff[70:64]) * 65'd59;
      v64    = acc_ff[64] ? acc_ff[63:0] + 64'd59 : acc_ff[63:0];
   end

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      if (mul_req.start) begin
         run_in = 1'b1;
         cnt_in = 3'd0;
         a_in   = mul_req.a;
         b_in   = mul_req.b;
         acc_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 3'd1;
         case (cnt_ff)
            3'd0: acc_in = acc_ff + {64'b0, pp};
            3'd1,
            3'd2: acc_in = acc_ff + {32'b0, pp, 32'b0};
            3'd3: acc_in = acc_ff + {pp, 64'b0};
            3'd4: acc_in = {57'b0, t71};
            3'd5: acc_in = {63'b0, u65};
            3'd6: begin
               prod_in = spgh_pkg::reduce_once(v64);
               done_in = 1'b1;
               run_in  = 1'b0;
            end
            default: run_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

endmodule
`default_nettype wire

### hdl/sparse_poly_grad_hessian_mod_p_unit.sv
// Top level: sparse homogeneous polynomial value, gradient and Hessian mod 2^64-59.
// Depends on spgh_pkg and spgh_mulmod.
//
// Issue a transaction by raising start while busy is low; it is taken at that
// edge. Load (op 0) returns nothing. Clear (op 1) runs a sweep over all 4096
// Hessian entries and the gradient store; the same sweep runs after reset,
// and busy stays high throughout. A term (op 2) reads its d coordinates
// (S_FETCH, then S_FETCH_CAP for each), then walks eleven job slots (value,
// up to four gradient entries, up to six Hessian pairs); a slot not used at
// this degree or order is skipped in S_JOB. A job starts in S_JOB, issues
// each multiply to the shared multiplier from S_CHAIN and waits in
// S_MUL_WAIT, skips excluded factors in S_CHAIN, closes the chain there,
// then does a read-modify-write on the accumulator (S_ACC_RD, S_ACC_WR;
// twice for a Hessian pair, S_ACC_RD only for the value job). A term with
// a bad index returns its result the cycle after it is taken and busy never
// rises. A read (op 3) returns the cycle after it is taken, or passes through
// S_RD_WAIT first when it reads the gradient or Hessian store. Every result
// appears on rsp_result_value / rsp_index_error for exactly one cycle with
// rsp_valid; there is no backpressure, the receiver must take it then.
// Configuration writes on csr_we are to be made only while the block is
// idle.
`default_nettype none
module sparse_poly_grad_hessian_mod_p_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [63:0] req_value,
   input  wire logic [5:0]  req_var_a,
   input  wire logic [5:0]  req_var_b,
   input  wire logic [5:0]  req_var_c,
   input  wire logic [5:0]  req_var_d,
   input  wire logic [1:0]  req_target,
   input  wire logic [5:0]  req_row,
   input  wire logic [5:0]  req_col,
   output logic             rsp_valid,
   output logic [63:0]      rsp_result_value,
   output logic             rsp_index_error,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_wdata
);

   // control state
   spgh_pkg::state_type state_ff, state_in;
   logic [11:0] clr_cnt_ff, clr_cnt_in;
   logic [2:0]  kcnt_ff, kcnt_in;
   logic [3:0]  job_ff, job_in;
   logic        pass_ff, pass_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  degree_ff, degree_in;
   logic [1:0]  order_ff, order_in;
   logic [6:0]  num_vars_ff, num_vars_in;
   logic [63:0] value_acc_ff, value_acc_in;

   // transaction payload
   logic [63:0] coef_ff, coef_in, chain_ff, chain_in;
   logic [5:0]  idx_ff [4];
   logic [5:0]  idx_in [4];
   logic [63:0] x_ff [4];
   logic [63:0] x_in [4];
   logic [2:0]  deg_ff, deg_in;
   logic [1:0]  ord_ff, ord_in;
   logic        rd_hess_ff, rd_hess_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_err_ff, rsp_err_in;

   // memories
   logic [63:0] pt_mem   [spgh_pkg::MAX_VARS];
   logic [63:0] grad_mem [spgh_pkg::MAX_VARS];
   logic [63:0] hess_mem [spgh_pkg::MAX_VARS * spgh_pkg::MAX_VARS];
   logic        pt_we, grad_we, hess_we;
   logic [spgh_pkg::VAR_W-1:0]   pt_raddr, grad_addr;
   logic [spgh_pkg::HESS_AW-1:0] hess_addr;
   logic [63:0] pt_wdata, grad_wdata, hess_wdata;
   logic [63:0] pt_rdata_ff, grad_rdata_ff, hess_rdata_ff;

   spgh_pkg::mul_req_type  mul_req;
   spgh_pkg::mul_rsp_type  mul_rsp;
   spgh_pkg::job_info_type info;

   // decode
   logic       accept;
   logic [6:0] lim;
   logic [2:0] deg_eff;
   logic [1:0] ord_eff;
   logic       term_err, row_bad, col_bad, rd_mem;
   logic       job_ok, incl;

   spgh_mulmod u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   always_comb begin
      accept  = start && (state_ff == spgh_pkg::S_IDLE);
      lim     = (num_vars_ff > 7'd64) ? 7'd64 : num_vars_ff;
      deg_eff = (degree_ff < 3'd2) ? 3'd2 : ((degree_ff > 3'd4) ? 3'd4 : degree_ff);
      ord_eff = (order_ff == 2'd3) ? 2'd2 : order_ff;
      term_err = ({1'b0, req_var_a} >= lim) || ({1'b0, req_var_b} >= lim)
              || ((deg_eff >= 3'd3) && ({1'b0, req_var_c} >= lim))
              || ((deg_eff == 3'd4) && ({1'b0, req_var_d} >= lim));
      row_bad = {1'b0, req_row} >= lim;
      col_bad = {1'b0, req_col} >= lim;
      rd_mem  = ((req_target == spgh_pkg::TGT_GRAD) && !row_bad && (ord_eff >= 2'd1))
             || ((req_target == spgh_pkg::TGT_HESS) && !row_bad && !col_bad
                 && (ord_eff == 2'd2));
      info    = spgh_pkg::job_info(job_ff);
      job_ok  = (info.kind == spgh_pkg::JOB_VALUE)
             || ((info.kind == spgh_pkg::JOB_GRAD) && (ord_ff >= 2'd1)
                 && ({1'b0, info.i} < deg_ff))
             || ((info.kind == spgh_pkg::JOB_HESS) && (ord_ff == 2'd2)
                 && ({1'b0, info.j} < deg_ff));
      // factor kcnt is part of this job's product
      incl    = !((info.kind == spgh_pkg::JOB_GRAD) && (kcnt_ff[1:0] == info.i))
             && !((info.kind == spgh_pkg::JOB_HESS)
                  && ((kcnt_ff[1:0] == info.i) || (kcnt_ff[1:0] == info.j)));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spgh_pkg::S_CLEAR:
            if (clr_cnt_ff == 12'hFFF) state_in = spgh_pkg::S_IDLE;
         spgh_pkg::S_IDLE:
            if (accept) begin
               case (spgh_pkg::op_type'(req_op))
                  spgh_pkg::OP_CLEAR: state_in = spgh_pkg::S_CLEAR;
                  spgh_pkg::OP_TERM:  if (!term_err) state_in = spgh_pkg::S_FETCH;
                  spgh_pkg::OP_READ:  if (rd_mem) state_in = spgh_pkg::S_RD_WAIT;
                  default:            state_in = spgh_pkg::S_IDLE;
               endcase
            end
         spgh_pkg::S_FETCH:     state_in = spgh_pkg::S_FETCH_CAP;
         spgh_pkg::S_FETCH_CAP:
            state_in = (kcnt_ff + 3'd1 == deg_ff) ? spgh_pkg::S_JOB : spgh_pkg::S_FETCH;
         spgh_pkg::S_JOB:
            if (job_ff == spgh_pkg::NUM_JOBS) state_in = spgh_pkg::S_IDLE;
            else if (job_ok) state_in = spgh_pkg::S_CHAIN;
         spgh_pkg::S_CHAIN:
            if (kcnt_ff == deg_ff) state_in = spgh_pkg::S_ACC_RD;
            else if (incl) state_in = spgh_pkg::S_MUL_WAIT;
         spgh_pkg::S_MUL_WAIT:
            if (mul_rsp.done) state_in = spgh_pkg::S_CHAIN;
         spgh_pkg::S_ACC_RD:
            state_in = (info.kind == spgh_pkg::JOB_VALUE) ? spgh_pkg::S_JOB
                                                           : spgh_pkg::S_ACC_WR;
         spgh_pkg::S_ACC_WR:
            state_in = ((info.kind == spgh_pkg::JOB_HESS) && !pass_ff) ? spgh_pkg::S_ACC_RD
                                                                      : spgh_pkg::S_JOB;
         spgh_pkg::S_RD_WAIT:   state_in = spgh_pkg::S_IDLE;
         default:               state_in = spgh_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      kcnt_in      = kcnt_ff;
      job_in       = job_ff;
      pass_in      = pass_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      value_acc_in = value_acc_ff;
      coef_in      = coef_ff;
      chain_in     = chain_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      deg_in       = deg_ff;
      ord_in       = ord_ff;
      rd_hess_in   = rd_hess_ff;
      degree_in    = degree_ff;
      order_in     = order_ff;
      num_vars_in  = num_vars_ff;
      mul_req      = '{start: 1'b0, a: chain_ff, b: x_ff[kcnt_ff[1:0]]};
      pt_we        = 1'b0;
      pt_wdata     = spgh_pkg::reduce_once(req_value);
      pt_raddr     = idx_ff[kcnt_ff[1:0]];
      grad_we      = 1'b0;
      grad_wdata   = spgh_pkg::mod_add(grad_rdata_ff, chain_ff);
      grad_addr    = idx_ff[info.i];
      hess_we      = 1'b0;
      hess_wdata   = spgh_pkg::mod_add(hess_rdata_ff, chain_ff);
      hess_addr    = pass_ff ? {idx_ff[info.j], idx_ff[info.i]}
                             : {idx_ff[info.i], idx_ff[info.j]};

      if (csr_we) begin
         case (csr_index)
            spgh_pkg::CSR_DEGREE:   degree_in   = csr_wdata[2:0];
            spgh_pkg::CSR_ORDER:    order_in    = csr_wdata[1:0];
            spgh_pkg::CSR_NUM_VARS: num_vars_in = csr_wdata;
            default:                num_vars_in = num_vars_ff;
         endcase
      end

      case (state_ff)
         spgh_pkg::S_CLEAR: begin
            grad_addr  = clr_cnt_ff[5:0];
            hess_addr  = clr_cnt_ff;
            grad_we    = 1'b1;
            hess_we    = 1'b1;
            grad_wdata = '0;
            hess_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 12'd1;
         end
         spgh_pkg::S_IDLE: begin
            grad_addr = req_row;
            hess_addr = {req_row, req_col};
            if (accept) begin
               case (spgh_pkg::op_type'(req_op))
                  spgh_pkg::OP_LOAD: pt_we = 1'b1;
                  spgh_pkg::OP_CLEAR: begin
                     value_acc_in = '0;
                     clr_cnt_in   = '0;
                  end
                  spgh_pkg::OP_TERM: begin
                     coef_in   = spgh_pkg::reduce_once(req_value);
                     idx_in[0] = req_var_a;
                     idx_in[1] = req_var_b;
                     idx_in[2] = req_var_c;
                     idx_in[3] = req_var_d;
                     deg_in    = deg_eff;
                     ord_in    = ord_eff;
                     kcnt_in   = 3'd0;
                     job_in    = 4'd0;
                     pass_in   = 1'b0;
                     if (term_err) begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                        rsp_err_in   = 1'b1;
                     end
                  end
                  spgh_pkg::OP_READ: begin
                     rd_hess_in   = (req_target == spgh_pkg::TGT_HESS);
                     rsp_value_in = (req_target == spgh_pkg::TGT_VALUE) ? value_acc_ff : '0;
                     rsp_err_in   = ((req_target == spgh_pkg::TGT_GRAD) && row_bad)
                                 || ((req_target == spgh_pkg::TGT_HESS)
                                     && (row_bad || col_bad));
                     rsp_valid_in = !rd_mem;
                  end
                  default: pt_we = 1'b0;
               endcase
            end
         end
         spgh_pkg::S_FETCH_CAP: begin
            x_in[kcnt_ff[1:0]] = pt_rdata_ff;
            kcnt_in = kcnt_ff + 3'd1;
         end
         spgh_pkg::S_JOB: begin
            kcnt_in  = 3'd0;
            chain_in = coef_ff;
            if (job_ff == spgh_pkg::NUM_JOBS) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_err_in   = 1'b0;
            end else if (!job_ok) begin
               job_in = job_ff + 4'd1;
            end
         end
         spgh_pkg::S_CHAIN:
            if (kcnt_ff != deg_ff) begin
               if (incl) mul_req.start = 1'b1;
               else kcnt_in = kcnt_ff + 3'd1;
            end
         spgh_pkg::S_MUL_WAIT:
            if (mul_rsp.done) begin
               chain_in = mul_rsp.product;
               kcnt_in  = kcnt_ff + 3'd1;
            end
         spgh_pkg::S_ACC_RD:
            if (info.kind == spgh_pkg::JOB_VALUE) begin
               value_acc_in = spgh_pkg::mod_add(value_acc_ff, chain_ff);
               job_in       = job_ff + 4'd1;
            end
         spgh_pkg::S_ACC_WR: begin
            if (info.kind == spgh_pkg::JOB_GRAD) grad_we = 1'b1;
            else hess_we = 1'b1;
            if ((info.kind == spgh_pkg::JOB_HESS) && !pass_ff) begin
               pass_in = 1'b1;
            end else begin
               pass_in = 1'b0;
               job_in  = job_ff + 4'd1;
            end
         end
         spgh_pkg::S_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_hess_ff ? hess_rdata_ff : grad_rdata_ff;
         end
         default: rsp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spgh_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         kcnt_ff      <= '0;
         job_ff       <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         degree_ff    <= 3'd3;
         order_ff     <= 2'd2;
         num_vars_ff  <= 7'd5;
         value_acc_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         kcnt_ff      <= kcnt_in;
         job_ff       <= job_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         degree_ff    <= degree_in;
         order_ff     <= order_in;
         num_vars_ff  <= num_vars_in;
         value_acc_ff <= value_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff      <= coef_in;
      chain_ff     <= chain_in;
      idx_ff       <= idx_in;
      x_ff         <= x_in;
      deg_ff       <= deg_in;
      ord_ff       <= ord_in;
      rd_hess_ff   <= rd_hess_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[req_row] <= pt_wdata;
      pt_rdata_ff <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (grad_we) grad_mem[grad_addr] <= grad_wdata;
      grad_rdata_ff <= grad_mem[grad_addr];
   end

   always_ff @(posedge clock) begin
      if (hess_we) hess_mem[hess_addr] <= hess_wdata;
      hess_rdata_ff <= hess_mem[hess_addr];
   end

   assign busy             = (state_ff != spgh_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_index_error  = rsp_err_ff;

endmodule
`default_nettype wire

### hdl/spgh_checker.sv
// Port-level checks for the sparse polynomial unit, bound to the top level.
// Depends on spgh_pkg.
`default_nettype none
module spgh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_op,
   input wire logic        rsp_valid,
   input wire logic [63:0] rsp_result_value,
   input wire logic        rsp_index_error
);

   // reset always launches the clearing sweep
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // a flagged transaction carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (rsp_result_value == 64'd0))
      else $error("index error with nonzero value");

   // a coordinate load produces no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == spgh_pkg::OP_LOAD)) |=> !rsp_valid)
      else $error("result after load");

   // a clear produces no result and occupies the unit
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == spgh_pkg::OP_CLEAR)) |=> (busy && !rsp_valid))
      else $error("clear did not start sweep");

endmodule

bind sparse_poly_grad_hessian_mod_p_unit spgh_checker u_spgh_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_op           (req_op),
   .rsp_valid        (rsp_valid),
   .rsp_result_value (rsp_result_value),
   .rsp_index_error  (rsp_index_error)
);
`default_nettype wire
